[sv/date_time_difference_assert.svh]
// Assertion macros for the date/time difference block
`ifndef DATE_TIME_DIFFERENCE_ASSERT_SVH
`define DATE_TIME_DIFFERENCE_ASSERT_SVH
`define DTD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[sv/dtd_pkg.sv]
// Shared types, codes and calendar helpers for the date/time difference block
`default_nettype none
package dtd_pkg;
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MONTH = 3'd1;
  localparam logic [2:0] ST_BAD_YEAR  = 3'd2;
  localparam logic [2:0] ST_BAD_DAY   = 3'd3;
  localparam logic [2:0] ST_BAD_HOUR  = 3'd4;
  localparam logic [2:0] ST_BAD_MIN   = 3'd5;
  localparam logic [2:0] ST_NOT_LATER = 3'd6;

  localparam logic [13:0] CUR_YEAR_RST = 14'd2024;

  typedef struct packed {
    logic load;
    logic step;
    logic fin;
  } dtd_cmd_t;

  typedef struct packed {
    logic err;
    logic done;
  } dtd_sts_t;

  // leap rule; divisible by 25 iff y * 7209 (inverse of 25 mod 2^14) lands at or below 655
  function automatic logic leap(input logic [13:0] y);
    logic [13:0] q;
    logic        by25;
    q = 14'(y * 14'd7209);
    by25 = (q <= 14'd655);
    leap = (y[1:0] == 2'd0) && (!by25 || (y[3:2] == 2'd0));
  endfunction

  function automatic logic [4:0] mdays(input logic [13:0] y, input logic [3:0] m);
    case (m)
      4'd2: mdays = leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: mdays = 5'd30;
      default: mdays = 5'd31;
    endcase
  endfunction

  function automatic logic [8:0] mstart(input logic [3:0] m);
    case (m)
      4'd1: mstart = 9'd0;
      4'd2: mstart = 9'd31;
      4'd3: mstart = 9'd59;
      4'd4: mstart = 9'd90;
      4'd5: mstart = 9'd120;
      4'd6: mstart = 9'd151;
      4'd7: mstart = 9'd181;
      4'd8: mstart = 9'd212;
      4'd9: mstart = 9'd243;
      4'd10: mstart = 9'd273;
      4'd11: mstart = 9'd304;
      default: mstart = 9'd334;
    endcase
  endfunction
endpackage
`default_nettype wire

[sv/dtd_ctrl.sv]
// Control state machine: load, iterate year days, finish
`default_nettype none
module dtd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire dtd_pkg::dtd_sts_t sts,
  output dtd_pkg::dtd_cmd_t    cmd
);
  import dtd_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;
  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.err || sts.done) state_nxt = S_FIN;
        else cmd.step = 1'b1;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

[sv/dtd_dp.sv]
// Datapath: checks, borrow span, iterative day count and totals
`default_nettype none
module dtd_dp (
  input  wire logic        clk,
  input  wire logic [13:0] cur_year,
  input  wire dtd_pkg::dtd_cmd_t cmd,
  output dtd_pkg::dtd_sts_t sts,
  input  wire logic [13:0] in_from_year,
  input  wire logic [3:0]  in_from_month,
  input  wire logic [4:0]  in_from_day,
  input  wire logic [4:0]  in_from_hour,
  input  wire logic [5:0]  in_from_minute,
  input  wire logic [13:0] in_to_year,
  input  wire logic [3:0]  in_to_month,
  input  wire logic [4:0]  in_to_day,
  input  wire logic [4:0]  in_to_hour,
  input  wire logic [5:0]  in_to_minute,
  input  wire logic        in_with_time,
  output logic [2:0]  out_status,
  output logic [8:0]  out_span_years,
  output logic [3:0]  out_span_months,
  output logic [4:0]  out_span_days,
  output logic [4:0]  out_span_hours,
  output logic [5:0]  out_span_minutes,
  output logic [12:0] out_total_months,
  output logic [17:0] out_total_days,
  output logic [21:0] out_total_hours,
  output logic [27:0] out_total_minutes
);
  import dtd_pkg::*;

  logic [2:0]  st_r;
  logic [13:0] yc_r, y1_r;
  logic [8:0]  sy_r;
  logic [3:0]  sm_r;
  logic [4:0]  sd_r, sh_r;
  logic [5:0]  sn_r;
  logic        dec_r;
  logic [17:0] td_r;
  logic [21:0] th;
  logic [27:0] tn;

  logic [4:0]  h0, h1;
  logic [5:0]  n0, n1;
  logic [2:0]  chk;
  logic [14:0] ylo, yhi;
  logic signed [7:0]  an, ah, ad, am;
  logic signed [15:0] ay;
  logic        hb;
  logic [3:0]  pm;
  logic [13:0] py;
  logic [17:0] off0, off1;
  logic [8:0]  yadd;

  always_comb begin
    h0 = in_with_time ? in_from_hour : 5'd0;
    h1 = in_with_time ? in_to_hour : 5'd0;
    n0 = in_with_time ? in_from_minute : 6'd0;
    n1 = in_with_time ? in_to_minute : 6'd0;
    yhi = {1'b0, cur_year} + 15'd200;
    ylo = {1'b0, in_from_year} + 15'd199;
    chk = ST_OK;
    if (in_from_month < 4'd1 || in_from_month > 4'd12) chk = ST_BAD_MONTH;
    else if ({1'b0, in_from_year} > yhi || ylo < {1'b0, cur_year}) chk = ST_BAD_YEAR;
    else if (in_from_day < 5'd1 || in_from_day > mdays(in_from_year, in_from_month))
      chk = ST_BAD_DAY;
    else if (in_with_time && h0 > 5'd23) chk = ST_BAD_HOUR;
    else if (in_with_time && n0 > 6'd59) chk = ST_BAD_MIN;
    else if (in_to_month < 4'd1 || in_to_month > 4'd12) chk = ST_BAD_MONTH;
    else if ({1'b0, in_to_year} > yhi ||
             ({1'b0, in_to_year} + 15'd199) < {1'b0, cur_year}) chk = ST_BAD_YEAR;
    else if (in_to_day < 5'd1 || in_to_day > mdays(in_to_year, in_to_month))
      chk = ST_BAD_DAY;
    else if (in_with_time && h1 > 5'd23) chk = ST_BAD_HOUR;
    else if (in_with_time && n1 > 6'd59) chk = ST_BAD_MIN;
    else if ({in_to_year, in_to_month, in_to_day, h1, n1} <=
             {in_from_year, in_from_month, in_from_day, h0, n0}) chk = ST_NOT_LATER;

    an = 8'(signed'({2'b0, n1})) - 8'(signed'({2'b0, n0}));
    ah = 8'(signed'({3'b0, h1})) - 8'(signed'({3'b0, h0}));
    ad = 8'(signed'({3'b0, in_to_day})) - 8'(signed'({3'b0, in_from_day}));
    am = 8'(signed'({4'b0, in_to_month})) - 8'(signed'({4'b0, in_from_month}));
    ay = 16'(signed'({2'b0, in_to_year})) - 16'(signed'({2'b0, in_from_year}));
    hb = 1'b0;
    if (an < 0) begin
      an = an + 8'sd60;
      ah = ah - 8'sd1;
    end
    if (ah < 0) begin
      ah = ah + 8'sd24;
      ad = ad - 8'sd1;
      hb = 1'b1;
    end
    pm = (in_to_month == 4'd1) ? 4'd12 : in_to_month - 4'd1;
    py = (in_to_month == 4'd1) ? in_to_year - 14'd1 : in_to_year;
    if (ad < 0) begin
      ad = ad + 8'(signed'({3'b0, mdays(py, pm)}));
      am = am - 8'sd1;
      if (ad < 0) ad = 8'sd0;
    end
    if (am < 0) begin
      am = am + 8'sd12;
      ay = ay - 16'sd1;
    end
    if (ay < 0) ay = 16'sd0;

    off0 = 18'(mstart(in_from_month)) + 18'(in_from_day) +
           ((in_from_month > 4'd2 && leap(in_from_year)) ? 18'd1 : 18'd0);
    off1 = 18'(mstart(in_to_month)) + 18'(in_to_day) +
           ((in_to_month > 4'd2 && leap(in_to_year)) ? 18'd1 : 18'd0);
    yadd = leap(yc_r) ? 9'd366 : 9'd365;
  end

  assign sts.err  = (st_r != ST_OK);
  assign sts.done = (yc_r == y1_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st_r  <= chk;
      yc_r  <= in_from_year;
      y1_r  <= in_to_year;
      sy_r  <= ay[8:0];
      sm_r  <= am[3:0];
      sd_r  <= ad[4:0];
      sh_r  <= ah[4:0];
      sn_r  <= an[5:0];
      dec_r <= hb;
      td_r  <= off1 - off0;
    end else if (cmd.step) begin
      yc_r <= yc_r + 14'd1;
      td_r <= td_r + 18'(yadd);
    end else if (cmd.fin) begin
      if (dec_r) td_r <= td_r - 18'd1;
    end
  end

  assign th = 22'(td_r) * 22'd24 + 22'(sh_r);
  assign tn = 28'(th) * 28'd60 + 28'(sn_r);

  always_comb begin
    out_status = st_r;
    out_span_years = 9'd0; out_span_months = 4'd0; out_span_days = 5'd0;
    out_span_hours = 5'd0; out_span_minutes = 6'd0; out_total_months = 13'd0;
    out_total_days = 18'd0; out_total_hours = 22'd0; out_total_minutes = 28'd0;
    if (st_r == ST_OK) begin
      out_span_years = sy_r;
      out_span_months = sm_r;
      out_span_days = sd_r;
      out_span_hours = sh_r;
      out_span_minutes = sn_r;
      out_total_months = 13'(sy_r) * 13'd12 + 13'(sm_r);
      out_total_days = td_r;
      out_total_hours = th;
      out_total_minutes = tn;
    end
  end
endmodule
`default_nettype wire

[sv/date_time_difference.sv]
// Calendar date/time difference: one item per request, result held until taken.
// An item is loaded, stepped year by year up to the later date, finished and
// held until taken; a rejected item skips the year steps. The day total is
// built by a year-by-year add loop in the datapath. Configuration (current_year)
// must be written only while the block is idle; the block does not enforce this.
`default_nettype none
module date_time_difference (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [13:0] cfg_current_year,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [13:0] in_from_year,
  input  wire logic [3:0]  in_from_month,
  input  wire logic [4:0]  in_from_day,
  input  wire logic [4:0]  in_from_hour,
  input  wire logic [5:0]  in_from_minute,
  input  wire logic [13:0] in_to_year,
  input  wire logic [3:0]  in_to_month,
  input  wire logic [4:0]  in_to_day,
  input  wire logic [4:0]  in_to_hour,
  input  wire logic [5:0]  in_to_minute,
  input  wire logic        in_with_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [8:0]       out_span_years,
  output logic [3:0]       out_span_months,
  output logic [4:0]       out_span_days,
  output logic [4:0]       out_span_hours,
  output logic [5:0]       out_span_minutes,
  output logic [12:0]      out_total_months,
  output logic [17:0]      out_total_days,
  output logic [21:0]      out_total_hours,
  output logic [27:0]      out_total_minutes
);
  import dtd_pkg::*;
  `include "date_time_difference_assert.svh"

  logic [13:0] cur_year_r;
  dtd_cmd_t cmd;
  dtd_sts_t sts;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) cur_year_r <= CUR_YEAR_RST;
    else if (cfg_valid) cur_year_r <= cfg_current_year;
  end

  dtd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  dtd_dp u_dp (
    .clk, .cur_year(cur_year_r), .cmd, .sts,
    .in_from_year, .in_from_month, .in_from_day, .in_from_hour, .in_from_minute,
    .in_to_year, .in_to_month, .in_to_day, .in_to_hour, .in_to_minute,
    .in_with_time, .out_status, .out_span_years, .out_span_months, .out_span_days,
    .out_span_hours, .out_span_minutes, .out_total_months, .out_total_days,
    .out_total_hours, .out_total_minutes
  );

  `DTD_ASSERT_IMPL(a_no_accept_busy, out_valid, in_stall)
  `DTD_ASSERT_IMPL(a_err_zero, out_valid && out_status != ST_OK, out_total_days == 18'd0)
  `DTD_ASSERT_NEXT(a_load_busy, cmd.load, in_stall)
endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Testbench for the date/time difference block: scoreboard class, drivers, checker
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dtd_pkg::*;

  typedef struct packed {
    logic [13:0] fy; logic [3:0] fm; logic [4:0] fd; logic [4:0] fh; logic [5:0] fn;
    logic [13:0] ty; logic [3:0] tm; logic [4:0] td; logic [4:0] th; logic [5:0] tn;
    logic wt;
  } req_t;

  typedef struct packed {
    logic [2:0] st; logic [8:0] sy; logic [3:0] smo; logic [4:0] sd; logic [4:0] sh;
    logic [5:0] smi; logic [12:0] tmo; logic [17:0] tday; logic [21:0] thr;
    logic [27:0] tmin;
  } span_t;

  class span_board;
    span_t pending[$];
    int unsigned year_now = 2024;
    int errors = 0;

    function automatic int unsigned is_leap(int unsigned y);
      return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    function automatic int unsigned month_days(int unsigned y, int unsigned m);
      int unsigned l[12] = '{31,28,31,30,31,30,31,31,30,31,30,31};
      return l[(m + 11) % 12] + ((m == 2) ? is_leap(y) : 0);
    endfunction

    function automatic longint day_index(int unsigned y, int unsigned m, int unsigned d);
      int unsigned s[12] = '{0,31,59,90,120,151,181,212,243,273,304,334};
      longint n;
      n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + s[(m + 11) % 12] + d;
      if (m > 2) n += is_leap(y);
      return n;
    endfunction

    function automatic logic [2:0] date_status(int unsigned y, int unsigned m, int unsigned d);
      int cy;
      cy = year_now;
      if (m < 1 || m > 12) return ST_BAD_MONTH;
      if (int'(y) > cy + 200 || int'(y) < cy - 199) return ST_BAD_YEAR;
      if (d < 1 || d > month_days(y, m)) return ST_BAD_DAY;
      return ST_OK;
    endfunction

    function automatic logic [2:0] time_status(int unsigned h, int unsigned n);
      if (h > 23) return ST_BAD_HOUR;
      if (n > 59) return ST_BAD_MIN;
      return ST_OK;
    endfunction

    function void note_request(req_t r);
      span_t e;
      int unsigned h0, n0, h1, n1, pm, py;
      longint ay, am, ad, ah, an, tdy, tmo, thr;
      logic [63:0] a, b;
      e = '0;
      h0 = r.wt ? r.fh : 0; n0 = r.wt ? r.fn : 0;
      h1 = r.wt ? r.th : 0; n1 = r.wt ? r.tn : 0;
      e.st = date_status(r.fy, r.fm, r.fd);
      if (e.st == ST_OK && r.wt) e.st = time_status(h0, n0);
      if (e.st == ST_OK) e.st = date_status(r.ty, r.tm, r.td);
      if (e.st == ST_OK && r.wt) e.st = time_status(h1, n1);
      if (e.st == ST_OK) begin
        a = {r.fy, 4'(r.fm), 5'(r.fd), 5'(h0), 6'(n0)};
        b = {r.ty, 4'(r.tm), 5'(r.td), 5'(h1), 6'(n1)};
        if (b <= a) e.st = ST_NOT_LATER;
      end
      if (e.st == ST_OK) begin
        ay = longint'(r.ty) - r.fy; am = longint'(r.tm) - r.fm;
        ad = longint'(r.td) - r.fd; ah = longint'(h1) - h0; an = longint'(n1) - n0;
        tdy = day_index(r.ty, r.tm, r.td) - day_index(r.fy, r.fm, r.fd);
        if (an < 0) begin an += 60; ah--; end
        if (ah < 0) begin ah += 24; ad--; tdy--; end
        if (ad < 0) begin
          pm = (r.tm == 1) ? 12 : r.tm - 1;
          py = (r.tm == 1) ? r.ty - 1 : r.ty;
          ad += month_days(py, pm);
          am--;
          if (ad < 0) ad = 0;
        end
        if (am < 0) begin am += 12; ay--; end
        if (ay < 0) ay = 0;
        if (tdy < 0) tdy = 0;
        tmo = ay * 12 + am; thr = tdy * 24 + ah;
        e.sy = 9'(ay); e.smo = 4'(am); e.sd = 5'(ad); e.sh = 5'(ah); e.smi = 6'(an);
        e.tmo = 13'(tmo); e.tday = 18'(tdy); e.thr = 22'(thr);
        e.tmin = 28'(thr * 60 + an);
      end
      pending.push_back(e);
    endfunction

    function void check_span(span_t got);
      span_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual %p", $realtime, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        $display("%0t mismatch: expected %p, actual %p", $realtime, e, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [13:0] cfg_current_year = 14'd2024;
  logic in_valid = 0, in_stall;
  req_t rq = '0;
  logic out_valid, out_stall = 0;
  span_t got;
  span_board sb;
  int idle_cycles = 0;

  date_time_difference uut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_current_year,
    .in_valid, .in_stall,
    .in_from_year(rq.fy), .in_from_month(rq.fm), .in_from_day(rq.fd),
    .in_from_hour(rq.fh), .in_from_minute(rq.fn),
    .in_to_year(rq.ty), .in_to_month(rq.tm), .in_to_day(rq.td),
    .in_to_hour(rq.th), .in_to_minute(rq.tn), .in_with_time(rq.wt),
    .out_valid, .out_stall,
    .out_status(got.st), .out_span_years(got.sy), .out_span_months(got.smo),
    .out_span_days(got.sd), .out_span_hours(got.sh), .out_span_minutes(got.smi),
    .out_total_months(got.tmo), .out_total_days(got.tday),
    .out_total_hours(got.thr), .out_total_minutes(got.tmin)
  );

  initial begin
    sb = new();
    forever #5 clk = ~clk;
  end

  // result side: random stall, check at rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_span(got);
  end
  initial begin
    int w;
    forever begin
      @(negedge clk);
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("date_time_difference regression: fail");
      $finish;
    end
  end

  task automatic write_year(input int unsigned y);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_current_year <= 14'(y);
    do @(posedge clk); while (!cfg_ready);
    sb.year_now = y;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send(input req_t r, input bit no_gap);
    int w;
    w = no_gap ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (w > 0) begin
      repeat (w - 1) @(negedge clk);
    end
    rq <= r;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (450) @(negedge clk);
  endtask

  function automatic req_t good_pair(input int unsigned cy, input int unsigned span_max);
    req_t r;
    int unsigned lo;
    lo = cy - 199;
    r.fy = 14'(lo + $urandom_range(0, 399));
    r.ty = 14'(r.fy + $urandom_range(0, span_max));
    if (r.ty > cy + 200) r.ty = 14'(cy + 200);
    r.fm = 4'($urandom_range(1, 12)); r.tm = 4'($urandom_range(1, 12));
    r.fd = 5'($urandom_range(1, sb.month_days(r.fy, r.fm)));
    r.td = 5'($urandom_range(1, sb.month_days(r.ty, r.tm)));
    r.fh = 5'($urandom_range(0, 23)); r.th = 5'($urandom_range(0, 23));
    r.fn = 6'($urandom_range(0, 59)); r.tn = 6'($urandom_range(0, 59));
    r.wt = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic req_t mk(int fy, int fm, int fd, int fh, int fn,
                              int ty, int tm, int td, int th, int tn, bit wt);
    req_t r;
    r.fy = 14'(fy); r.fm = 4'(fm); r.fd = 5'(fd); r.fh = 5'(fh); r.fn = 6'(fn);
    r.ty = 14'(ty); r.tm = 4'(tm); r.td = 5'(td); r.th = 5'(th); r.tn = 6'(tn);
    r.wt = wt;
    return r;
  endfunction

  initial begin
    int unsigned years[6] = '{2024, 200, 9799, 1000, 2000, 5000};
    req_t r;
    int k;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed
    send(mk(2024, 1, 1, 0, 0, 2024, 12, 31, 23, 59, 1), 0);
    send(mk(2024, 0, 1, 0, 0, 2024, 1, 1, 0, 0, 0), 0);
    send(mk(2024, 15, 1, 0, 0, 2024, 1, 1, 0, 0, 0), 0);
    send(mk(1824, 1, 1, 0, 0, 2024, 1, 1, 0, 0, 0), 0);
    send(mk(1825, 1, 1, 0, 0, 2224, 12, 31, 0, 0, 0), 0);
    send(mk(2024, 1, 1, 0, 0, 2225, 1, 1, 0, 0, 0), 0);
    send(mk(16383, 1, 1, 0, 0, 2024, 1, 1, 0, 0, 0), 0);
    send(mk(2023, 2, 29, 0, 0, 2024, 2, 29, 0, 0, 0), 0);
    send(mk(2024, 4, 31, 0, 0, 2024, 5, 0, 0, 0, 0), 0);
    send(mk(2024, 1, 1, 24, 0, 2024, 1, 2, 0, 0, 1), 0);
    send(mk(2024, 1, 1, 31, 63, 2024, 1, 2, 0, 0, 0), 0);
    send(mk(2024, 1, 1, 0, 60, 2024, 1, 2, 0, 0, 1), 0);
    send(mk(2024, 1, 1, 0, 0, 2024, 1, 2, 23, 63, 1), 0);
    send(mk(2024, 1, 1, 5, 5, 2024, 1, 1, 5, 5, 1), 0);
    send(mk(2024, 1, 1, 5, 5, 2024, 1, 1, 9, 9, 0), 0);
    send(mk(2024, 1, 31, 0, 0, 2024, 3, 1, 0, 0, 0), 0);
    send(mk(2023, 1, 31, 0, 0, 2023, 3, 1, 0, 0, 0), 0);
    send(mk(2023, 12, 31, 23, 59, 2024, 1, 1, 0, 0, 1), 0);
    send(mk(2000, 2, 28, 0, 0, 2100, 3, 1, 0, 0, 0), 0);
    send(mk(1825, 1, 1, 0, 0, 2224, 12, 31, 23, 59, 1), 0);
    drain();

    // pressure pause done by each drain between settings
    for (k = 0; k < 6; k++) begin
      write_year(years[k]);
      if (k == 1) send(mk(0, 2, 29, 0, 0, 1, 1, 1, 0, 0, 0), 0);
      for (int i = 0; i < 272; i++) begin
        case ($urandom_range(0, 9))
          0: r = req_t'(69'({$urandom, $urandom, $urandom}));
          1: begin
            r = good_pair(years[k], 3);
            r.ty = r.fy;
            r.tm = r.fm;
            r.td = (r.fd > 1 && $urandom_range(0, 1)) ? r.fd - 5'd1 : r.fd;
          end
          2: r = good_pair(years[k], 399);
          default: r = good_pair(years[k], 4);
        endcase
        send(r, $urandom_range(0, 4) == 0);
      end
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("date_time_difference regression: pass");
    else
      $display("date_time_difference regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
